// File: rtl/aes128_block_cipher_macros.svh
// Assertion macros for the AES-128 block cipher.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication.
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/aes_pkg.sv
// Shared constants, types and round functions of the AES-128 block cipher.
// No dependencies; used by the channel interfaces and the top level.
package aes_pkg;

    localparam int HALF_W    = 64;
    localparam int NUM_RND   = 10;
    localparam int CFG_IDX_W = 2;

    typedef logic [2*HALF_W-1:0]  blk_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [3:0]           rnd_t;

    localparam cfg_idx_t KEY_HIGH_IDX = 2'd0;
    localparam cfg_idx_t KEY_LOW_IDX  = 2'd1;

    localparam logic MODE_DEC = 1'b1;

    // Substitution tables, entry 0 in the top byte.
    localparam logic [2047:0] FWD_V = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_V = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return FWD_V[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] x);
        return INV_V[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input rnd_t k);
        logic [7:0] r;
        case (k)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Byte i of the state sits at bits 127-8i down.
    function automatic blk_t sub_bytes(input blk_t s, input logic inv);
        blk_t t;
        for (int i = 0; i < 16; i++) begin
            t[127-8*i -: 8] = inv ? sbox_inv(s[127-8*i -: 8]) : sbox(s[127-8*i -: 8]);
        end
        return t;
    endfunction

    // Row r rotates left by r for encryption and right by r for decryption.
    function automatic blk_t shift_rows(input blk_t s, input logic inv);
        blk_t t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c-r+4)&3)) -: 8];
                end
                else begin
                    t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] mix_col_inv(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++) begin
            a[i]  = w[31-8*i -: 8];
            x2    = xt(a[i]);
            x4    = xt(x2);
            x8    = xt(x4);
            m9[i] = x8 ^ a[i];
            mb[i] = x8 ^ x2 ^ a[i];
            md[i] = x8 ^ x4 ^ a[i];
            me[i] = x8 ^ x4 ^ x2;
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic blk_t mix_columns(input blk_t s, input logic inv);
        blk_t t;
        for (int c = 0; c < 4; c++) begin
            t[127-32*c -: 32] = inv ? mix_col_inv(s[127-32*c -: 32]) : mix_col(s[127-32*c -: 32]);
        end
        return t;
    endfunction

    // One cipher round; the final round leaves out the column mix.
    function automatic blk_t round_fn(input blk_t s, input blk_t k, input logic inv,
                                      input logic last);
        blk_t t;
        if (inv) begin
            t = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ k;
            if (!last) begin
                t = mix_columns(t, 1'b1);
            end
        end
        else begin
            t = shift_rows(sub_bytes(s, 1'b0), 1'b0);
            if (!last) begin
                t = mix_columns(t, 1'b0);
            end
            t = t ^ k;
        end
        return t;
    endfunction

    // Next round key from the previous one.
    function automatic blk_t key_next(input blk_t w, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
        w0 = w[127:96] ^ t;
        w1 = w[95:64] ^ w0;
        w2 = w[63:32] ^ w1;
        w3 = w[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: rtl/aes_ifs.sv
// Valid/ready channel interfaces of the AES-128 block cipher.
// Depends on aes_pkg for field widths.
interface aes_blk_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [aes_pkg::HALF_W-1:0] block_high;
    logic [aes_pkg::HALF_W-1:0] block_low;
    modport source (output valid, req_type, block_high, block_low, input ready);
    modport sink   (input valid, req_type, block_high, block_low, output ready);
endinterface

interface aes_res_if;
    logic                      valid;
    logic                      ready;
    logic [aes_pkg::HALF_W-1:0] out_high;
    logic [aes_pkg::HALF_W-1:0] out_low;
    modport source (output valid, out_high, out_low, input ready);
    modport sink   (input valid, out_high, out_low, output ready);
endinterface

interface aes_cfg_if;
    logic                      valid;
    logic                      ready;
    aes_pkg::cfg_idx_t         index;
    logic [aes_pkg::HALF_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/aes128_block_cipher.sv
// AES-128 encrypt/decrypt pipeline of eleven stages: an initial key addition, then one
// round per register stage. One block per cycle sustained while the result side is free.
// After reset or a key write the key schedule runs, one round key a cycle,
// and input ready stays low meanwhile. Reset is asynchronous, active low on rst_n,
// and clears the key to zero and empties the pipeline.
`include "aes128_block_cipher_macros.svh"

module aes128_block_cipher (
    input  logic     clk,
    input  logic     rst_n,
    aes_blk_if.sink  blk,
    aes_res_if.source res,
    aes_cfg_if.sink  cfg
);

    // Key registers and schedule sequencer.
    logic [aes_pkg::HALF_W-1:0] key_high_reg;
    logic [aes_pkg::HALF_W-1:0] key_low_reg;
    logic                       busy_reg;
    aes_pkg::rnd_t              cnt_reg;
    aes_pkg::blk_t              wk_reg;
    aes_pkg::blk_t              wk_next;
    aes_pkg::blk_t              rk_reg [aes_pkg::NUM_RND+1];

    // Round pipeline: stage 0 holds the initial key addition, stage k round k.
    // The mode bit of stage k steers round k+1, so the last stage needs none.
    aes_pkg::blk_t              st_reg [aes_pkg::NUM_RND+1];
    aes_pkg::blk_t              st_next [1:aes_pkg::NUM_RND];
    logic [aes_pkg::NUM_RND-1:0] md_reg;
    logic [aes_pkg::NUM_RND:0]  vl_reg;

    logic cfg_wr;
    logic restart;
    logic adv;
    logic in_xfer;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign restart   = cfg_wr && ((cfg.index == aes_pkg::KEY_HIGH_IDX) ||
                                  (cfg.index == aes_pkg::KEY_LOW_IDX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                aes_pkg::KEY_HIGH_IDX: key_high_reg <= cfg.data;
                aes_pkg::KEY_LOW_IDX:  key_low_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // The schedule restarts on every key write; the last round key lands when the
    // count reaches the round count, which then releases input ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (restart)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == aes_pkg::rnd_t'(aes_pkg::NUM_RND))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign wk_next = (cnt_reg == '0) ? {key_high_reg, key_low_reg}
                                     : aes_pkg::key_next(wk_reg, aes_pkg::rcon(cnt_reg));

    always_ff @(posedge clk)
    begin
        if (busy_reg && !restart)
        begin
            wk_reg <= wk_next;
            for (int i = 0; i <= aes_pkg::NUM_RND; i++)
            begin
                if (cnt_reg == aes_pkg::rnd_t'(i))
                begin
                    rk_reg[i] <= wk_next;
                end
            end
        end
    end

    // The whole pipeline moves together whenever the result register is free or
    // its transfer completes, so a stall holds every stage in place.
    assign adv       = !vl_reg[aes_pkg::NUM_RND] || res.ready;
    assign blk.ready = adv && !busy_reg;
    assign in_xfer   = blk.valid && blk.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg <= '0;
        end
        else if (adv)
        begin
            vl_reg <= {vl_reg[aes_pkg::NUM_RND-1:0], in_xfer};
        end
    end

    // Decryption walks the round keys from the last one back to the first.
    for (genvar k = 1; k <= aes_pkg::NUM_RND; k++)
    begin : g_round
        assign st_next[k] = aes_pkg::round_fn(
            st_reg[k-1],
            (md_reg[k-1] == aes_pkg::MODE_DEC) ? rk_reg[aes_pkg::NUM_RND-k] : rk_reg[k],
            md_reg[k-1] == aes_pkg::MODE_DEC,
            k == aes_pkg::NUM_RND);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= {blk.block_high, blk.block_low} ^
                         ((blk.req_type == aes_pkg::MODE_DEC) ? rk_reg[aes_pkg::NUM_RND]
                                                              : rk_reg[0]);
            md_reg[0] <= blk.req_type;
            for (int k = 1; k <= aes_pkg::NUM_RND; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            for (int k = 1; k < aes_pkg::NUM_RND; k++)
            begin
                md_reg[k] <= md_reg[k-1];
            end
        end
    end

    assign res.valid    = vl_reg[aes_pkg::NUM_RND];
    assign res.out_high = st_reg[aes_pkg::NUM_RND][2*aes_pkg::HALF_W-1:aes_pkg::HALF_W];
    assign res.out_low  = st_reg[aes_pkg::NUM_RND][aes_pkg::HALF_W-1:0];

    `AES_ASSERT_NEXT(a_xfer_enters, in_xfer, vl_reg[0], "accepted block missing in stage 0")
    `AES_ASSERT_NEXT(a_stall_holds, !adv, $stable(vl_reg), "pipeline moved during a stall")
    `AES_ASSERT_NEXT(a_key_restart, restart, busy_reg && (cnt_reg == '0),
                     "key write did not restart the schedule")
    `AES_ASSERT_NOW(a_no_xfer_busy, busy_reg, !in_xfer, "block taken during key schedule")

endmodule

// File: tb/aes128_cipher_checker.sv
// Checker for the AES-128 block cipher: watches the key, block and result channels.
// It predicts each result with its own AES model and counts mismatches.
// Depends on aes_pkg and the channel interfaces in aes_ifs.sv.
module aes128_cipher_checker (
    input  logic      clk,
    input  logic      rst_n,
    aes_blk_if.sink   blk,
    aes_res_if.sink   res,
    aes_cfg_if.sink   cfg,
    output int        errors,
    output int        pending,
    output int        results_seen
);

    logic [7:0] enc_tab [256];
    logic [7:0] dec_tab [256];
    logic [aes_pkg::HALF_W-1:0] key_hi, key_lo;
    aes_pkg::blk_t cipher_q [$];

    // Standard substitution table built from the field inverse and the affine map.
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    initial
    begin
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            enc_tab[x] = s;
            dec_tab[s] = x[7:0];
        end
    end

    function automatic aes_pkg::blk_t predict_cipher(input logic decrypt,
                                                     input aes_pkg::blk_t din);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] t [16];
        logic [7:0] w [4];
        logic [7:0] f, rc;
        logic [7:0] m [4];
        aes_pkg::blk_t kk, r;
        kk = {key_hi, key_lo};
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = kk[127-8*i -: 8];
            st[i] = din[127-8*i -: 8];
        end
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = rk[i-4+j];
            if (i % 16 == 0)
            begin
                f = w[0];
                w[0] = enc_tab[w[1]] ^ rc;
                w[1] = enc_tab[w[2]];
                w[2] = enc_tab[w[3]];
                w[3] = enc_tab[f];
                rc = gmul(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++)
                rk[i+j] = rk[i-16+j] ^ w[j];
        end
        if (decrypt)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int i = 0; i < 16; i++)
            st[i] ^= rk[(decrypt ? 160 : 0) + i];
        for (int step = 1; step <= 10; step++)
        begin
            // Substitute and rotate rows; the inverse steps commute in this order.
            for (int rr = 0; rr < 4; rr++)
                for (int c = 0; c < 4; c++)
                    if (decrypt)
                        t[rr+4*((c+rr)&3)] = dec_tab[st[rr+4*c]];
                    else
                        t[rr+4*c] = enc_tab[st[rr+4*((c+rr)&3)]];
            st = t;
            if (decrypt)
                for (int i = 0; i < 16; i++)
                    st[i] ^= rk[16*(10-step)+i];
            if (step < 10)
                for (int c = 0; c < 4; c++)
                begin
                    for (int rr = 0; rr < 4; rr++)
                        t[4*c+rr] = gmul(st[4*c], m[(4-rr)&3]) ^ gmul(st[4*c+1], m[(5-rr)&3])
                                  ^ gmul(st[4*c+2], m[(6-rr)&3])
                                  ^ gmul(st[4*c+3], m[(7-rr)&3]);
                end
            if (step < 10)
                for (int i = 0; i < 16; i++)
                    st[i] = t[i];
            if (!decrypt)
                for (int i = 0; i < 16; i++)
                    st[i] ^= rk[16*step+i];
        end
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = st[i];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [aes_pkg::HALF_W-1:0] got,
                                   input logic [aes_pkg::HALF_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    assign pending = cipher_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        aes_pkg::blk_t want;
        if (!rst_n)
        begin
            key_hi <= '0;
            key_lo <= '0;
            cipher_q.delete();
            errors <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                results_seen <= results_seen + 1;
                if (cipher_q.size() == 0)
                    report_mismatch("unexpected result", res.out_high, '0);
                else
                begin
                    want = cipher_q.pop_front();
                    if (res.out_high !== want[127:64])
                        report_mismatch("out_high", res.out_high, want[127:64]);
                    if (res.out_low !== want[63:0])
                        report_mismatch("out_low", res.out_low, want[63:0]);
                end
            end
            if (blk.valid && blk.ready)
                cipher_q.push_back(predict_cipher(blk.req_type == aes_pkg::MODE_DEC,
                                                  {blk.block_high, blk.block_low}));
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == aes_pkg::KEY_HIGH_IDX)
                    key_hi <= cfg.data;
                else if (cfg.index == aes_pkg::KEY_LOW_IDX)
                    key_lo <= cfg.data;
            end
        end
    end
endmodule

// File: tb/tb_aes128_block_cipher.sv
// Top of the AES-128 block cipher testbench: clock, reset, key writes and block stimulus.
// Depends on aes_pkg, aes_ifs.sv, the block itself and aes128_cipher_checker.
module tb_aes128_block_cipher;

    // Register indexes with no register behind them.
    localparam aes_pkg::cfg_idx_t SPARE_IDX_A = 2'd2;
    localparam aes_pkg::cfg_idx_t SPARE_IDX_B = 2'd3;

    logic clk;
    logic rst_n;
    int   errors, pending, results_seen;
    int   blocks_sent;
    int   key_sets;

    // Receiver behavior: random stalls, a quiet stretch, and one long hold-off.
    bit   no_idle;
    bit   hold_off;

    aes_blk_if blk ();
    aes_res_if res ();
    aes_cfg_if cfg ();

    aes128_block_cipher uut (.clk(clk), .rst_n(rst_n), .blk(blk), .res(res), .cfg(cfg));

    aes128_cipher_checker chk (
        .clk(clk), .rst_n(rst_n), .blk(blk), .res(res), .cfg(cfg),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The result side stalls with a probability of about one in five, except during the quiet stretch.
    // While hold_off is set it stays low so the pipeline backs up into the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_off)
            res.ready <= 1'b0;
        else
            res.ready <= no_idle || ($urandom_range(99) >= 20);
    end

    // Long hold-off counted in cycles, started once partway through the random blocks.
    initial
    begin
        hold_off = 1'b0;
        wait (blocks_sent == 200);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (60)
            @(posedge clk);
        hold_off = 1'b0;
    end

    // Writes one key register; the transfer completes when the block takes it.
    task automatic write_key_reg(input aes_pkg::cfg_idx_t idx,
                                 input logic [aes_pkg::HALF_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Offers one block and holds it until the block is transferred, with an
    // occasional random gap before it.
    task automatic send_block(input logic decrypt, input logic [aes_pkg::HALF_W-1:0] hi,
                              input logic [aes_pkg::HALF_W-1:0] lo);
        if (!no_idle && $urandom_range(99) < 20)
        begin
            blk.valid <= 1'b0;
            repeat ($urandom_range(3, 1))
                @(posedge clk);
        end
        blk.valid      <= 1'b1;
        blk.req_type   <= decrypt;
        blk.block_high <= hi;
        blk.block_low  <= lo;
        @(posedge clk);
        while (!blk.ready)
            @(posedge clk);
        blocks_sent++;
    endtask

    // Drops the block valid, then lets every expected result drain.
    task automatic drain;
        blk.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (15)
            @(posedge clk);
    endtask

    task automatic load_key(input logic [aes_pkg::HALF_W-1:0] hi,
                            input logic [aes_pkg::HALF_W-1:0] lo);
        write_key_reg(aes_pkg::KEY_HIGH_IDX, hi);
        write_key_reg(aes_pkg::KEY_LOW_IDX, lo);
        key_sets++;
    endtask

    function automatic logic [aes_pkg::HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [aes_pkg::HALF_W-1:0] h, l;
        blocks_sent    = 0;
        key_sets       = 0;
        no_idle        = 1'b0;
        rst_n          = 1'b0;
        blk.valid      = 1'b0;
        blk.req_type   = 1'b0;
        blk.block_high = '0;
        blk.block_low  = '0;
        cfg.valid      = 1'b0;
        cfg.index      = aes_pkg::KEY_HIGH_IDX;
        cfg.data       = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. First the all-zero key that reset leaves behind.
        send_block(1'b0, '0, '0);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '1, '1);
        send_block(1'b1, '1, '1);
        drain();

        // The FIPS-197 appendix vector, both directions.
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
        drain();

        // A write to an index with no register behind it must leave the key alone.
        write_key_reg(SPARE_IDX_A, rand64());
        write_key_reg(SPARE_IDX_B, rand64());
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();

        // All-ones key, with one half rewritten alone afterward.
        load_key('1, '1);
        send_block(1'b0, '0, '0);
        send_block(1'b1, '1, '0);
        drain();
        write_key_reg(aes_pkg::KEY_LOW_IDX, 64'h0123456789abcdef);
        send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        drain();

        // Random part in phases, each under a fresh key, with random blocks sent in random
        // directions. One phase runs with no idling at all.
        for (int phase = 0; phase < 5; phase++)
        begin
            load_key(rand64(), rand64());
            no_idle = (phase == 2);
            for (int n = 0; n < 100; n++)
            begin
                h = rand64();
                l = rand64();
                send_block(1'($urandom_range(1)), h, l);
            end
            no_idle = 1'b0;
            drain();
        end

        $display("Sent %0d blocks under %0d key settings; %0d results checked.",
                 blocks_sent, key_sets, results_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule
